// ----- sv/compass_heading_atan2_top_macros.svh -----
// Assertion macros for the compass heading block and its checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef COMPASS_HEADING_ATAN2_TOP_MACROS_SVH
`define COMPASS_HEADING_ATAN2_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CMPATAN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CMPATAN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cmpatan_pkg.sv -----
// Package for the compass heading block: widths, codes, CORDIC angle table.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package cmpatan_pkg;

    localparam int IN_W       = 16;
    localparam int DIFF_W     = 17;
    localparam int ANGLE_FRAC = 24;
    localparam int XY_W       = 43;
    localparam int Z_W        = 34;
    localparam int HEADING_W  = 15;
    localparam int TABLE_LEN  = 24;
    localparam int ATAN_W     = 30;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X = 1'b0,
        REG_OFFSET_Y = 1'b1
    } cfg_reg_t;

    localparam logic signed [IN_W-1:0] OFFSET_X_RST = -16'sd2631;
    localparam logic signed [IN_W-1:0] OFFSET_Y_RST = -16'sd4739;

    localparam logic signed [Z_W-1:0] Z_DEG90  = Z_W'(90) << ANGLE_FRAC;
    localparam logic signed [Z_W-1:0] Z_DEG180 = Z_W'(180) << ANGLE_FRAC;
    localparam logic signed [Z_W-1:0] Z_DEG270 = Z_W'(270) << ANGLE_FRAC;
    localparam logic signed [Z_W-1:0] Z_DEG360 = Z_W'(360) << ANGLE_FRAC;

    // atan(2^-i) in degrees, scaled by 2^24
    localparam logic [ATAN_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
        30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
        30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
        30'd234684,    30'd117342,    30'd58671,     30'd29335,
        30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_beat_t;

endpackage

`default_nettype wire

// ----- sv/cmpatan_in_if.sv -----
// Input channel: one raw magnetometer sample per beat.
// Depends on cmpatan_pkg for field widths.
`default_nettype none

interface cmpatan_in_if;
    import cmpatan_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] mag_x;
    logic signed [IN_W-1:0] mag_y;

    modport source (output valid, output mag_x, output mag_y, input ready);
    modport sink   (input valid, input mag_x, input mag_y, output ready);
endinterface

`default_nettype wire

// ----- sv/cmpatan_out_if.sv -----
// Output channel: one heading per beat.
// Depends on cmpatan_pkg for field widths.
`default_nettype none

interface cmpatan_out_if;
    import cmpatan_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [HEADING_W-1:0] heading;

    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface

`default_nettype wire

// ----- sv/cmpatan_prep.sv -----
// Front stage: offset subtraction, half-plane fold and axis special cases.
// Depends on cmpatan_pkg.
`default_nettype none

module cmpatan_prep
    import cmpatan_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic signed [IN_W-1:0] mag_x,
    input  logic signed [IN_W-1:0] mag_y,
    input  logic signed [IN_W-1:0] offset_x,
    input  logic signed [IN_W-1:0] offset_y,
    output logic                   out_vld,
    output cordic_beat_t           out_beat
);

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dx_fold;
    logic signed [DIFF_W-1:0] dy_fold;
    logic                     vld_reg;
    cordic_beat_t             beat_reg;
    cordic_beat_t             beat_next;

    assign dx      = {mag_x[IN_W-1], mag_x} - {offset_x[IN_W-1], offset_x};
    assign dy      = {mag_y[IN_W-1], mag_y} - {offset_y[IN_W-1], offset_y};
    assign dx_fold = dx[DIFF_W-1] ? -dx : dx;
    assign dy_fold = dx[DIFF_W-1] ? -dy : dy;

    always_comb
    begin
        beat_next.x = {{(XY_W-DIFF_W-ANGLE_FRAC){dx_fold[DIFF_W-1]}}, dx_fold,
                       {ANGLE_FRAC{1'b0}}};
        beat_next.y = {{(XY_W-DIFF_W-ANGLE_FRAC){dy_fold[DIFF_W-1]}}, dy_fold,
                       {ANGLE_FRAC{1'b0}}};
        beat_next.z = dx[DIFF_W-1] ? Z_DEG180 : '0;
        // on the y axis the angle is exact and no rotation happens
        if (dx == '0)
        begin
            beat_next.x = '0;
            beat_next.y = '0;
            if (dy == '0)
            begin
                beat_next.z = '0;
            end
            else if (dy[DIFF_W-1])
            begin
                beat_next.z = Z_DEG270;
            end
            else
            begin
                beat_next.z = Z_DEG90;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_beat = beat_reg;

endmodule

`default_nettype wire

// ----- sv/cmpatan_cell.sv -----
// One CORDIC vectoring micro-rotation with its pipeline register.
// Depends on cmpatan_pkg for the beat type and angle table.
`default_nettype none

module cmpatan_cell
    import cmpatan_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_vld,
    input  cordic_beat_t in_beat,
    output logic         out_vld,
    output cordic_beat_t out_beat
);

    localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(ATAN_TABLE[STEP]);

    logic signed [XY_W-1:0] x_sh;
    logic signed [XY_W-1:0] y_sh;
    logic                   vld_reg;
    cordic_beat_t           beat_reg;
    cordic_beat_t           beat_next;

    assign x_sh = in_beat.x >>> STEP;
    assign y_sh = in_beat.y >>> STEP;

    always_comb
    begin
        beat_next = in_beat;
        if (in_beat.y[XY_W-1])
        begin
            beat_next.x = in_beat.x - y_sh;
            beat_next.y = in_beat.y + x_sh;
            beat_next.z = in_beat.z - ATAN_STEP;
        end
        else if (in_beat.y != '0)
        begin
            beat_next.x = in_beat.x + y_sh;
            beat_next.y = in_beat.y - x_sh;
            beat_next.z = in_beat.z + ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_beat = beat_reg;

endmodule

`default_nettype wire

// ----- sv/cmpatan_wrap.sv -----
// Back stage: fold into 0..360, scale to the output fraction, output register.
// Depends on cmpatan_pkg.
`default_nettype none

module cmpatan_wrap
    import cmpatan_pkg::*;
#(
    parameter int FRACTION_BITS = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_vld,
    input  cordic_beat_t          in_beat,
    output logic                  out_vld,
    output logic [HEADING_W-1:0]  heading
);

    localparam int              SHIFT = ANGLE_FRAC - FRACTION_BITS;
    localparam logic [Z_W-1:0]  LIMIT = Z_W'(360) << FRACTION_BITS;

    logic signed [Z_W-1:0]  z_pos;
    logic [Z_W-1:0]         h_raw;
    logic [Z_W-1:0]         h_once;
    logic [Z_W-1:0]         h_wrap;
    logic                   vld_reg;
    logic [HEADING_W-1:0]   heading_reg;
    logic [HEADING_W-1:0]   heading_next;

    assign z_pos        = in_beat.z[Z_W-1] ? in_beat.z + Z_DEG360 : in_beat.z;
    assign h_raw        = $unsigned(z_pos) >> SHIFT;
    assign h_once       = (h_raw >= LIMIT) ? h_raw - LIMIT : h_raw;
    assign h_wrap       = (h_once >= LIMIT) ? '0 : h_once;
    assign heading_next = h_wrap[HEADING_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            heading_reg <= heading_next;
        end
    end

    assign out_vld = vld_reg;
    assign heading = heading_reg;

endmodule

`default_nettype wire

// ----- sv/compass_heading_atan2_top.sv -----
// Compass heading top level: offset registers, front stage, CORDIC cell chain,
// output stage. Depends on cmpatan_pkg, cmpatan_in_if, cmpatan_out_if and the
// cmpatan_prep, cmpatan_cell and cmpatan_wrap modules.
//
//   channel   dir  beat contents            handshake
//   sample    in   mag_x, mag_y             valid / ready
//   result    out  heading                  valid / ready
//   wr_*      in   wr_index, wr_data        wr_en, no back-pressure
//
// One sample accepted per cycle unless the pipeline holds; each sample passes
// through the front stage, one cell per micro-rotation and the output register.
// The whole pipeline advances together; it holds only while a result sits
// in the output register and result.ready is low.
// Reset clears all valid bits and loads the offset reset values.
`default_nettype none

module compass_heading_atan2_top
    import cmpatan_pkg::*;
#(
    parameter int CORDIC_STEPS  = 16,
    parameter int FRACTION_BITS = 6
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    cmpatan_in_if.sink             sample,
    cmpatan_out_if.source          result,
    input  logic                   wr_en,
    input  logic [CFG_IDX_W-1:0]   wr_index,
    input  logic [IN_W-1:0]        wr_data
);

    logic signed [IN_W-1:0] offset_x_reg;
    logic signed [IN_W-1:0] offset_y_reg;
    logic                   en;
    logic                   stage_vld  [CORDIC_STEPS+1];
    cordic_beat_t           stage_beat [CORDIC_STEPS+1];

    assign en           = !result.valid || result.ready;
    assign sample.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= OFFSET_X_RST;
            offset_y_reg <= OFFSET_Y_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_OFFSET_X: offset_x_reg <= wr_data;
                REG_OFFSET_Y: offset_y_reg <= wr_data;
                default:      offset_x_reg <= offset_x_reg;
            endcase
        end
    end

    cmpatan_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (sample.valid),
        .mag_x    (sample.mag_x),
        .mag_y    (sample.mag_y),
        .offset_x (offset_x_reg),
        .offset_y (offset_y_reg),
        .out_vld  (stage_vld[0]),
        .out_beat (stage_beat[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        cmpatan_cell #(
            .STEP (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (stage_vld[i]),
            .in_beat  (stage_beat[i]),
            .out_vld  (stage_vld[i+1]),
            .out_beat (stage_beat[i+1])
        );
    end

    cmpatan_wrap #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_wrap (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (stage_vld[CORDIC_STEPS]),
        .in_beat (stage_beat[CORDIC_STEPS]),
        .out_vld (result.valid),
        .heading (result.heading)
    );

endmodule

`default_nettype wire

// ----- sv/cmpatan_chk.sv -----
// Port-level checker for the compass heading block, bound to the top level.
// Depends on cmpatan_pkg and compass_heading_atan2_top_macros.svh.
`default_nettype none

`include "compass_heading_atan2_top_macros.svh"

module cmpatan_chk
    import cmpatan_pkg::*;
#(
    parameter int FRACTION_BITS = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [HEADING_W-1:0] heading
);

    localparam int LIMIT = 360 << FRACTION_BITS;

    `CMPATAN_ASSERT_IMP(a_heading_range, clk, rst_n, out_valid, (LIMIT > 32767) || (32'(heading) < LIMIT), "heading beyond 360 degrees")
    `CMPATAN_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(heading), "stalled result changed")
    `CMPATAN_ASSERT_IMP(a_ready_when_drained, clk, rst_n, out_ready || !out_valid, in_ready, "input stalled while output can move")
    `CMPATAN_ASSERT_IMP(a_stall_only_on_output, clk, rst_n, !in_ready, out_valid && !out_ready && !(in_valid && in_ready), "input stalled without output back-pressure")

endmodule

bind compass_heading_atan2_top cmpatan_chk #(
    .FRACTION_BITS (FRACTION_BITS)
) u_cmpatan_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .heading   (result.heading)
);

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for compass_heading_atan2_top: random and directed magnetometer samples.
// Checks every heading against a CORDIC model kept in the bench.
// Depends on cmpatan_pkg, cmpatan_in_if, cmpatan_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb;
    import cmpatan_pkg::*;

    localparam int     STEPS      = 16;
    localparam int     FRAC       = 6;
    localparam int     ANGLE_Q    = 24;
    localparam int     LIMIT      = 200000;
    localparam int     HOLD_LEN   = 100;
    localparam longint DEG180     = longint'(180) <<< ANGLE_Q;
    localparam longint DEG360     = longint'(360) <<< ANGLE_Q;

    // atan(2^-i) in degrees, Q24
    localparam longint ATAN_STEP_DEG [24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic signed [IN_W-1:0] mx;
        logic signed [IN_W-1:0] my;
    } sample_t;

    typedef struct packed {
        logic signed [IN_W-1:0]  mx;
        logic signed [IN_W-1:0]  my;
        logic [HEADING_W-1:0]    heading;
    } heading_due_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   wr_en;
    logic [CFG_IDX_W-1:0]   wr_index;
    logic [IN_W-1:0]        wr_data;

    cmpatan_in_if  sample_ch ();
    cmpatan_out_if result_ch ();

    sample_t                pending_samples [$];
    heading_due_t           headings_due [$];
    sample_t                beat;
    heading_due_t           want;
    logic signed [IN_W-1:0] off_x;
    logic signed [IN_W-1:0] off_y;
    logic                   no_idle;
    int                     hold_reqs;
    int                     hold_served;
    int                     stall_left;
    int                     errors;
    int                     cycle_count;

    compass_heading_atan2_top #(
        .CORDIC_STEPS  (STEPS),
        .FRACTION_BITS (FRAC)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [HEADING_W-1:0] heading_for_sample(
        input logic signed [IN_W-1:0] mx,
        input logic signed [IN_W-1:0] my,
        input logic signed [IN_W-1:0] ox,
        input logic signed [IN_W-1:0] oy);
        longint dx, dy, x, y, z, t, h, wrap;
        dx = longint'(mx) - longint'(ox);
        dy = longint'(my) - longint'(oy);
        if (dx == 0 && dy == 0)
            return '0;
        if (dx == 0)
        begin
            z = (dy > 0 ? longint'(90) : longint'(270)) <<< ANGLE_Q;
        end
        else
        begin
            x = dx <<< ANGLE_Q;
            y = dy <<< ANGLE_Q;
            z = 0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = DEG180;
            end
            for (int i = 0; i < STEPS && i < 24; i++)
            begin
                if (y > 0)
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    x = t;
                    z = z + ATAN_STEP_DEG[i];
                end
                else if (y < 0)
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    x = t;
                    z = z - ATAN_STEP_DEG[i];
                end
            end
            if (z < 0)
                z = z + DEG360;
        end
        if (z < 0)
            z = 0;
        h = z >>> (ANGLE_Q - FRAC);
        wrap = longint'(360) <<< FRAC;
        if (h >= wrap)
            h = h - wrap;
        if (h >= wrap)
            h = 0;
        return h[HEADING_W-1:0];
    endfunction

    task automatic flag_error(input string what);
        if (errors < 50)
            $display("ERROR @%0t: %s", $time, what);
        errors++;
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            sample_ch.mag_x <= '0;
            sample_ch.mag_y <= '0;
        end
        else if (!sample_ch.valid || sample_ch.ready)
        begin
            if (pending_samples.size() != 0 && (no_idle || $urandom_range(99) >= 11))
            begin
                beat = pending_samples.pop_front();
                sample_ch.valid <= 1'b1;
                sample_ch.mag_x <= beat.mx;
                sample_ch.mag_y <= beat.my;
            end
            else
            begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // receiver, with long hold-offs on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
            hold_served     <= 0;
        end
        else if (hold_served != hold_reqs)
        begin
            hold_served     <= hold_served + 1;
            stall_left      <= HOLD_LEN;
            result_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left      <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= no_idle || ($urandom_range(99) >= 11);
        end
    end

    // checker and heading prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (headings_due.size() == 0)
                begin
                    flag_error($sformatf("unexpected heading %0d", result_ch.heading));
                end
                else
                begin
                    want = headings_due.pop_front();
                    if (result_ch.heading !== want.heading)
                        flag_error($sformatf("x=%0d y=%0d: heading %0d, want %0d",
                            want.mx, want.my, result_ch.heading, want.heading));
                end
            end
            if (sample_ch.valid && sample_ch.ready)
                headings_due.push_back('{sample_ch.mag_x, sample_ch.mag_y,
                    heading_for_sample(sample_ch.mag_x, sample_ch.mag_y, off_x, off_y)});
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("compass_heading_atan2_top: mismatch");
            $finish;
        end
    end

    task automatic write_offset(input cfg_reg_t idx, input logic signed [IN_W-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en    <= 1'b0;
        if (idx == REG_OFFSET_X)
            off_x = val;
        else
            off_y = val;
    endtask

    task automatic set_offsets(input logic signed [IN_W-1:0] ox,
                               input logic signed [IN_W-1:0] oy);
        write_offset(REG_OFFSET_X, ox);
        write_offset(REG_OFFSET_Y, oy);
    endtask

    task automatic queue_sample(input logic signed [IN_W-1:0] mx,
                                input logic signed [IN_W-1:0] my);
        pending_samples.push_back('{mx, my});
    endtask

    // mostly full-range samples, some close to the offsets, some on an axis
    task automatic queue_random(input int n);
        int                     kind;
        logic signed [IN_W-1:0] mx;
        logic signed [IN_W-1:0] my;
        for (int k = 0; k < n; k++)
        begin
            kind = $urandom_range(9);
            mx   = 16'($urandom);
            my   = 16'($urandom);
            if (kind == 7 || kind == 8)
            begin
                mx = off_x + 16'(int'($urandom_range(16)) - 8);
                my = off_y + 16'(int'($urandom_range(16)) - 8);
            end
            else if (kind == 9)
            begin
                if ($urandom_range(1))
                    mx = off_x;
                else
                    my = off_y;
            end
            queue_sample(mx, my);
        end
    endtask

    // sampled mid-cycle so the sender's update at the edge is visible
    task automatic drain;
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || sample_ch.valid || headings_due.size() != 0);
    endtask

    task automatic request_hold;
        @(posedge clk);
        hold_reqs <= hold_reqs + 1;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        wr_en           = 1'b0;
        wr_index        = REG_OFFSET_X;
        wr_data         = '0;
        off_x           = -16'sd2631;
        off_y           = -16'sd4739;
        no_idle         = 1'b0;
        hold_reqs       = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset offsets: zero vector, straight up, straight down and one off-axis sample
        queue_sample(-16'sd2631, -16'sd4739);
        queue_sample(-16'sd2631, 16'sd0);
        queue_sample(-16'sd2631, -16'sd9000);
        queue_sample(16'sd1000, 16'sd1000);
        drain;

        set_offsets(16'sd0, 16'sd0);
        queue_sample(16'sd0, 16'sd0);
        queue_sample(16'sd0, 16'sd100);
        queue_sample(16'sd0, -16'sd100);
        queue_sample(16'sd100, 16'sd0);
        queue_sample(-16'sd100, 16'sd0);
        queue_sample(16'sd32767, 16'sd32767);
        queue_sample(-16'sd32768, -16'sd32768);
        queue_sample(16'sd32767, -16'sd32768);
        queue_sample(-16'sd32768, 16'sd32767);
        queue_sample(16'sd1, 16'sd1);
        queue_sample(-16'sd1, 16'sd1);
        queue_sample(16'sd1, -16'sd1);
        queue_sample(-16'sd1, -16'sd1);
        // just below the wrap to zero, then either side of 180 degrees
        queue_sample(16'sd32767, -16'sd1);
        queue_sample(-16'sd32768, 16'sd1);
        queue_sample(-16'sd32768, -16'sd1);
        drain;

        // offsets at the extremes: widest differences and zero vector
        set_offsets(-16'sd32768, 16'sd32767);
        queue_sample(16'sd32767, -16'sd32768);
        queue_sample(-16'sd32768, 16'sd32767);
        queue_sample(16'sd32767, 16'sd32767);
        queue_sample(-16'sd32768, -16'sd32768);
        drain;

        // stretch with no idling on either side
        set_offsets(16'($urandom), 16'($urandom));
        no_idle <= 1'b1;
        queue_random(100);
        drain;
        no_idle <= 1'b0;

        set_offsets(16'sd32767, -16'sd32768);
        queue_random(100);
        request_hold;
        drain;

        set_offsets(16'($urandom), 16'($urandom));
        queue_random(60);
        drain;
        queue_random(60);
        drain;

        set_offsets(16'sd0, 16'sd0);
        queue_random(100);
        request_hold;
        drain;

        set_offsets(-16'sd2631, -16'sd4739);
        queue_random(80);
        drain;

        repeat (STEPS + 8) @(posedge clk);
        if (errors == 0)
            $display("compass_heading_atan2_top: match");
        else
            $display("compass_heading_atan2_top: mismatch");
        $finish;
    end
endmodule
